>>> sv/lts_pkg.sv
// shared types and constants for the link traffic statistics block
// no dependencies; imported by the interfaces and the top level

package lts_pkg;

    localparam int KIND_W         = 2;
    localparam int BYTE_COUNT_W   = 11;
    localparam int FRAME_NUMBER_W = 31;
    localparam int FRAME_BYTES_W  = 24;
    localparam int PACKETS_W      = 16;
    localparam int WINDOW_BYTES_W = 32;
    localparam int NUM_DIRS       = 2;
    localparam int DIR_TX         = 0;
    localparam int DIR_RX         = 1;

    localparam int unsigned DEFAULT_WINDOW_FRAMES = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_TX        = 2'd0,
        KIND_RX        = 2'd1,
        KIND_FRAME_END = 2'd2
    } kind_t;

endpackage

>>> sv/lts_in_if.sv
// event channel into the link traffic statistics block
// depends on lts_pkg for field widths

interface lts_in_if
    import lts_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [BYTE_COUNT_W-1:0]   byte_count;
    logic [FRAME_NUMBER_W-1:0] frame_number;

    modport source (output valid, kind, byte_count, frame_number, input ready);
    modport sink (input valid, kind, byte_count, frame_number, output ready);
endinterface

>>> sv/lts_out_if.sv
// statistics result channel out of the link traffic statistics block
// depends on lts_pkg for field widths

interface lts_out_if
    import lts_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [WINDOW_BYTES_W-1:0] tx_bytes_window;
    logic [WINDOW_BYTES_W-1:0] rx_bytes_window;
    logic [PACKETS_W-1:0]      tx_packets_window;
    logic [PACKETS_W-1:0]      rx_packets_window;
    logic [WINDOW_BYTES_W-1:0] tx_bytes_window_peak;
    logic [WINDOW_BYTES_W-1:0] rx_bytes_window_peak;
    logic [PACKETS_W-1:0]      tx_packets_window_peak;
    logic [PACKETS_W-1:0]      rx_packets_window_peak;
    logic [FRAME_BYTES_W-1:0]  tx_bytes_frame_peak;
    logic [FRAME_BYTES_W-1:0]  rx_bytes_frame_peak;
    logic [PACKETS_W-1:0]      tx_packets_frame_peak;
    logic [PACKETS_W-1:0]      rx_packets_frame_peak;

    modport source (
        output valid, tx_bytes_window, rx_bytes_window, tx_packets_window,
               rx_packets_window, tx_bytes_window_peak, rx_bytes_window_peak,
               tx_packets_window_peak, rx_packets_window_peak, tx_bytes_frame_peak,
               rx_bytes_frame_peak, tx_packets_frame_peak, rx_packets_frame_peak,
        input  ready
    );
    modport sink (
        input  valid, tx_bytes_window, rx_bytes_window, tx_packets_window,
               rx_packets_window, tx_bytes_window_peak, rx_bytes_window_peak,
               tx_packets_window_peak, rx_packets_window_peak, tx_bytes_frame_peak,
               rx_bytes_frame_peak, tx_packets_frame_peak, rx_packets_frame_peak,
        output ready
    );
endinterface

>>> sv/link_traffic_statistics.sv
// link traffic statistics: frame and window byte/packet counters with peaks
// depends on lts_pkg, lts_in_if and lts_out_if
//
//  channel    dir   transaction
//  stat_in    in    one event: packet sent, packet received or frame end
//  stat_out   out   one snapshot of window values and peaks after that event
//
// one event per cycle sustained while stat_out takes every result
// stage a registers the event, stage b holds the window-close flag, the
// statistics registers double as the result register
// window close test folds the frame number through four 8-bit residue tables
// reset clears all counters, tallies and peaks to zero
// a stalled result holds; the two earlier stages still fill behind it

module link_traffic_statistics
    import lts_pkg::*;
#(
    parameter int unsigned WINDOW_FRAMES = DEFAULT_WINDOW_FRAMES
) (
    input  logic     clk,
    input  logic     rst_n,
    lts_in_if.sink   stat_in,
    lts_out_if.source stat_out
);

    localparam int RES_W = $clog2(WINDOW_FRAMES + 1);
    localparam int SUM_W = RES_W + 2;
    localparam logic [SUM_W-1:0] W1 = SUM_W'(WINDOW_FRAMES);
    localparam logic [SUM_W-1:0] W2 = SUM_W'(2 * WINDOW_FRAMES);
    localparam logic [SUM_W-1:0] W3 = SUM_W'(3 * WINDOW_FRAMES);

    // pipeline control
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic b_ready;
    logic a_ready;
    logic commit;

    // stage a payload
    kind_t                     a_kind_reg;
    logic [BYTE_COUNT_W-1:0]   a_bytes_reg;
    logic [FRAME_NUMBER_W-1:0] a_frame_reg;

    // stage b payload
    kind_t                   b_kind_reg;
    logic [BYTE_COUNT_W-1:0] b_bytes_reg;
    logic                    b_close_reg;

    // window close test
    logic [RES_W-1:0] res_tab [4][256];
    logic [31:0]      frame_wide;
    logic [SUM_W-1:0] res_sum;
    logic             close_flag;

    // statistics state
    logic [FRAME_BYTES_W-1:0]  frame_bytes_reg [NUM_DIRS];
    logic [FRAME_BYTES_W-1:0]  frame_bytes_next [NUM_DIRS];
    logic [PACKETS_W-1:0]      frame_pkts_reg [NUM_DIRS];
    logic [PACKETS_W-1:0]      frame_pkts_next [NUM_DIRS];
    logic [FRAME_BYTES_W-1:0]  fpeak_bytes_reg [NUM_DIRS];
    logic [FRAME_BYTES_W-1:0]  fpeak_bytes_next [NUM_DIRS];
    logic [PACKETS_W-1:0]      fpeak_pkts_reg [NUM_DIRS];
    logic [PACKETS_W-1:0]      fpeak_pkts_next [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] tally_bytes_reg [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] tally_bytes_next [NUM_DIRS];
    logic [PACKETS_W-1:0]      tally_pkts_reg [NUM_DIRS];
    logic [PACKETS_W-1:0]      tally_pkts_next [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] shown_bytes_reg [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] shown_bytes_next [NUM_DIRS];
    logic [PACKETS_W-1:0]      shown_pkts_reg [NUM_DIRS];
    logic [PACKETS_W-1:0]      shown_pkts_next [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] wpeak_bytes_reg [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] wpeak_bytes_next [NUM_DIRS];
    logic [PACKETS_W-1:0]      wpeak_pkts_reg [NUM_DIRS];
    logic [PACKETS_W-1:0]      wpeak_pkts_next [NUM_DIRS];

    // saturating sums
    logic [FRAME_BYTES_W:0]    byte_sum [NUM_DIRS];
    logic [FRAME_BYTES_W-1:0]  byte_sat [NUM_DIRS];
    logic [PACKETS_W-1:0]      pkt_sat [NUM_DIRS];
    logic [WINDOW_BYTES_W:0]   tally_b_sum [NUM_DIRS];
    logic [WINDOW_BYTES_W-1:0] tally_b_sat [NUM_DIRS];
    logic [PACKETS_W:0]        tally_p_sum [NUM_DIRS];
    logic [PACKETS_W-1:0]      tally_p_sat [NUM_DIRS];
    logic                      pkt_hit [NUM_DIRS];

    // handshake: each stage fills when it is empty or the one after it moves
    assign out_free       = !out_valid_reg || stat_out.ready;
    assign b_ready        = !b_valid_reg || out_free;
    assign a_ready        = !a_valid_reg || b_ready;
    assign commit         = b_valid_reg && out_free;
    assign stat_in.ready  = a_ready;
    assign stat_out.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= stat_in.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (stat_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && stat_in.valid)
        begin
            a_kind_reg  <= kind_t'(stat_in.kind);
            a_bytes_reg <= stat_in.byte_count;
            a_frame_reg <= stat_in.frame_number;
        end
        if (b_ready && a_valid_reg)
        begin
            b_kind_reg  <= a_kind_reg;
            b_bytes_reg <= a_bytes_reg;
            b_close_reg <= close_flag;
        end
    end

    // residue of (digit << 8*i) modulo the window length, per byte lane
    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        for (genvar j = 0; j < 256; j++)
        begin : g_entry
            localparam int unsigned RES =
                int'((longint'(j) << (8 * i)) % longint'(WINDOW_FRAMES));
            assign res_tab[i][j] = RES_W'(RES);
        end
    end

    assign frame_wide = {1'b0, a_frame_reg};

    // sum of four residues stays below four window lengths
    assign res_sum = SUM_W'(res_tab[0][frame_wide[7:0]])
                   + SUM_W'(res_tab[1][frame_wide[15:8]])
                   + SUM_W'(res_tab[2][frame_wide[23:16]])
                   + SUM_W'(res_tab[3][frame_wide[31:24]]);

    assign close_flag = (res_sum == '0) || (res_sum == W1) || (res_sum == W2)
                     || (res_sum == W3);

    always_comb
    begin
        pkt_hit[DIR_TX] = (b_kind_reg == KIND_TX);
        // an empty receive means nothing arrived
        pkt_hit[DIR_RX] = (b_kind_reg == KIND_RX) && (b_bytes_reg != '0);

        for (int d = 0; d < NUM_DIRS; d++)
        begin
            frame_bytes_next[d] = frame_bytes_reg[d];
            frame_pkts_next[d]  = frame_pkts_reg[d];
            fpeak_bytes_next[d] = fpeak_bytes_reg[d];
            fpeak_pkts_next[d]  = fpeak_pkts_reg[d];
            tally_bytes_next[d] = tally_bytes_reg[d];
            tally_pkts_next[d]  = tally_pkts_reg[d];
            shown_bytes_next[d] = shown_bytes_reg[d];
            shown_pkts_next[d]  = shown_pkts_reg[d];
            wpeak_bytes_next[d] = wpeak_bytes_reg[d];
            wpeak_pkts_next[d]  = wpeak_pkts_reg[d];

            byte_sum[d] = {1'b0, frame_bytes_reg[d]} + (FRAME_BYTES_W+1)'(b_bytes_reg);
            byte_sat[d] = byte_sum[d][FRAME_BYTES_W] ? '1 : byte_sum[d][FRAME_BYTES_W-1:0];
            pkt_sat[d]  = (&frame_pkts_reg[d]) ? frame_pkts_reg[d]
                                               : frame_pkts_reg[d] + PACKETS_W'(1);

            tally_b_sum[d] = {1'b0, tally_bytes_reg[d]}
                           + (WINDOW_BYTES_W+1)'(frame_bytes_reg[d]);
            tally_b_sat[d] = tally_b_sum[d][WINDOW_BYTES_W] ? '1
                           : tally_b_sum[d][WINDOW_BYTES_W-1:0];
            tally_p_sum[d] = {1'b0, tally_pkts_reg[d]} + {1'b0, frame_pkts_reg[d]};
            tally_p_sat[d] = tally_p_sum[d][PACKETS_W] ? '1 : tally_p_sum[d][PACKETS_W-1:0];

            case (b_kind_reg)
                KIND_TX, KIND_RX:
                begin
                    if (pkt_hit[d])
                    begin
                        frame_bytes_next[d] = byte_sat[d];
                        frame_pkts_next[d]  = pkt_sat[d];
                    end
                end
                KIND_FRAME_END:
                begin
                    if (frame_bytes_reg[d] > fpeak_bytes_reg[d])
                        fpeak_bytes_next[d] = frame_bytes_reg[d];
                    if (frame_pkts_reg[d] > fpeak_pkts_reg[d])
                        fpeak_pkts_next[d] = frame_pkts_reg[d];
                    frame_bytes_next[d] = '0;
                    frame_pkts_next[d]  = '0;
                    if (b_close_reg)
                    begin
                        // new window is shown and compared against the peak
                        shown_bytes_next[d] = tally_b_sat[d];
                        shown_pkts_next[d]  = tally_p_sat[d];
                        if (tally_b_sat[d] > wpeak_bytes_reg[d])
                            wpeak_bytes_next[d] = tally_b_sat[d];
                        if (tally_p_sat[d] > wpeak_pkts_reg[d])
                            wpeak_pkts_next[d] = tally_p_sat[d];
                        tally_bytes_next[d] = '0;
                        tally_pkts_next[d]  = '0;
                    end
                    else
                    begin
                        tally_bytes_next[d] = tally_b_sat[d];
                        tally_pkts_next[d]  = tally_p_sat[d];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // state only moves when the previous result has gone, so it is the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
            begin
                frame_bytes_reg[d] <= '0;
                frame_pkts_reg[d]  <= '0;
                fpeak_bytes_reg[d] <= '0;
                fpeak_pkts_reg[d]  <= '0;
                tally_bytes_reg[d] <= '0;
                tally_pkts_reg[d]  <= '0;
                shown_bytes_reg[d] <= '0;
                shown_pkts_reg[d]  <= '0;
                wpeak_bytes_reg[d] <= '0;
                wpeak_pkts_reg[d]  <= '0;
            end
        end
        else if (commit)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
            begin
                frame_bytes_reg[d] <= frame_bytes_next[d];
                frame_pkts_reg[d]  <= frame_pkts_next[d];
                fpeak_bytes_reg[d] <= fpeak_bytes_next[d];
                fpeak_pkts_reg[d]  <= fpeak_pkts_next[d];
                tally_bytes_reg[d] <= tally_bytes_next[d];
                tally_pkts_reg[d]  <= tally_pkts_next[d];
                shown_bytes_reg[d] <= shown_bytes_next[d];
                shown_pkts_reg[d]  <= shown_pkts_next[d];
                wpeak_bytes_reg[d] <= wpeak_bytes_next[d];
                wpeak_pkts_reg[d]  <= wpeak_pkts_next[d];
            end
        end
    end

    assign stat_out.tx_bytes_window        = shown_bytes_reg[DIR_TX];
    assign stat_out.rx_bytes_window        = shown_bytes_reg[DIR_RX];
    assign stat_out.tx_packets_window      = shown_pkts_reg[DIR_TX];
    assign stat_out.rx_packets_window      = shown_pkts_reg[DIR_RX];
    assign stat_out.tx_bytes_window_peak   = wpeak_bytes_reg[DIR_TX];
    assign stat_out.rx_bytes_window_peak   = wpeak_bytes_reg[DIR_RX];
    assign stat_out.tx_packets_window_peak = wpeak_pkts_reg[DIR_TX];
    assign stat_out.rx_packets_window_peak = wpeak_pkts_reg[DIR_RX];
    assign stat_out.tx_bytes_frame_peak    = fpeak_bytes_reg[DIR_TX];
    assign stat_out.rx_bytes_frame_peak    = fpeak_bytes_reg[DIR_RX];
    assign stat_out.tx_packets_frame_peak  = fpeak_pkts_reg[DIR_TX];
    assign stat_out.rx_packets_frame_peak  = fpeak_pkts_reg[DIR_RX];

    a_window_peak_covers_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (wpeak_bytes_reg[DIR_TX] >= shown_bytes_reg[DIR_TX])
        && (wpeak_bytes_reg[DIR_RX] >= shown_bytes_reg[DIR_RX]))
        else $error("window byte peak below shown window value");

    a_frame_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (fpeak_bytes_reg[DIR_TX] >= $past(fpeak_bytes_reg[DIR_TX]))
               && (fpeak_pkts_reg[DIR_RX] >= $past(fpeak_pkts_reg[DIR_RX])))
        else $error("frame peak decreased");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (b_kind_reg == KIND_FRAME_END)) |=>
            (frame_bytes_reg[DIR_TX] == '0) && (frame_pkts_reg[DIR_RX] == '0))
        else $error("frame counts not cleared at frame end");

    a_state_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(frame_bytes_reg[DIR_TX]) && $stable(tally_bytes_reg[DIR_RX]))
        else $error("statistics changed without a committed event");

endmodule
